[rtl/mwm_pkg.sv]
// Shared constants, types and table helper for the mecanum wheel mixer.
`default_nettype none
package mwm_pkg;

	// default sine table size
	localparam int SINE_ENTRIES_DEF = 1024;

	localparam int Q12_ONE   = 4096;
	localparam int FULL_TURN = 5760;
	localparam int HALF_TURN = 2880;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// reciprocal of a full turn, 2^37 / 5760 rounded up; exact for the
	// operand ranges used here
	localparam int REC_SHIFT = 37;
	localparam logic [24:0] REC_TURN = 25'(((64'd1 << 37) + 64'd5759) / 64'd5760);

	// datapath widths
	localparam int DW   = 14;       // command and drive fields
	localparam int WW   = 22;       // mixed wheel values, signed
	localparam int QW   = 13;       // normalised quotient
	localparam int NUMW = WW + 12;  // divider remainder

	// operation codes
	localparam logic [1:0] OP_XY_TURN = 2'd0;
	localparam logic [1:0] OP_RL_STRAFE = 2'd1;
	localparam logic [1:0] OP_FIELD = 2'd2;
	localparam logic [1:0] OP_HOLD = 2'd3;

	// register indexes
	localparam logic [2:0] CFG_SLOW_ON = 3'd0;
	localparam logic [2:0] CFG_SLOW_SCALE = 3'd1;
	localparam logic [2:0] CFG_INVERT = 3'd2;
	localparam logic [2:0] CFG_NORM_ON = 3'd3;
	localparam logic [2:0] CFG_HOLD_GAIN = 3'd4;

	typedef struct packed {
		logic [1:0]           op;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] turn;
		logic signed [DW-1:0] rs;
		logic signed [DW-1:0] ls;
		logic signed [DW-1:0] st;
	} cmd_t;

	// side data carried alongside the divider lanes
	typedef struct packed {
		logic                 act;
		logic [3:0]           neg;
		logic [3:0][WW-1:0]   w;
	} div_side_t;

	// sine in Q12 of x radians in Q30, first quadrant; elaboration only
	function automatic logic [12:0] quarter_sine(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t3;
		longint unsigned t5;
		longint unsigned t7;
		longint unsigned t9;
		longint s;
		x2 = (x * x) >> 30;
		t3 = ((x * x2) >> 30) / 6;
		t5 = ((t3 * x2) >> 30) / 20;
		t7 = ((t5 * x2) >> 30) / 42;
		t9 = ((t7 * x2) >> 30) / 72;
		s = longint'(x) - longint'(t3) + longint'(t5) - longint'(t7) + longint'(t9);
		if (s < 0) begin
			s = 0;
		end
		return 13'(($unsigned(s) + 64'd131072) >> 18);
	endfunction

endpackage
`default_nettype wire

[rtl/mwm_heading.sv]
// Heading pipeline: gyro reduction, hold turn and sine/cosine lookup.
`default_nettype none
module mwm_heading import mwm_pkg::*; #(
	parameter int ENTRIES = SINE_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic [6:0]            en,
	input  wire cmd_t                  cmd_in,
	input  wire logic [12:0]           target_in,
	input  wire logic signed [23:0]    gyro_in,
	input  wire logic [15:0]           hold_gain,
	output cmd_t                       cmd_out,
	output logic signed [DW-1:0]       sn_out,
	output logic signed [DW-1:0]       cs_out,
	output logic signed [19:0]         turn_out
);

	localparam int IW = $clog2(ENTRIES);
	localparam int QN = ENTRIES / 4;
	localparam int KW = IW - 1;
	localparam int VW = 13 + IW;

	// quarter wave table, built at elaboration
	logic [12:0] qtab [QN+1];
	for (genvar k = 0; k <= QN; k++) begin : g_tab
		localparam longint unsigned XK = (HALF_PI_Q30 * 64'(4 * k)) / 64'(ENTRIES);
		assign qtab[k] = quarter_sine(XK);
	end

	cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6, cmd_s7;
	logic [23:0]        gabs_s1, gabs_s2;
	logic               gneg_s1, gneg_s2, gneg_s3;
	logic signed [13:0] tadj_s1, tadj_s2, tadj_s3, tadj_s4;
	logic [10:0]        gq_s2;
	logic [12:0]        r_s3;
	logic signed [13:0] g_s4;
	logic [12:0]        m_s4;
	logic [IW:0]        iq_s5;
	logic signed [14:0] diff_s5;
	logic [IW-1:0]      idx_s6;
	logic signed [31:0] hprod_s6;
	logic signed [DW-1:0] sn_s7, cs_s7;
	logic signed [19:0] turn_s7;

	logic [48:0]        gprod;
	logic [VW-1:0]      vnum;
	logic [VW+24:0]     iprod;
	logic [IW-1:0]      cidx;
	logic [1:0]         sq, cq;
	logic [KW-1:0]      sk, ck;
	logic [12:0]        sval, cval;

	assign gprod = 49'(gabs_s1) * 49'(REC_TURN);
	assign vnum  = (VW'(m_s4) << IW) + VW'(HALF_TURN);
	assign iprod = (VW + 25)'(vnum) * (VW + 25)'(REC_TURN);

	// quadrant folding for both lookups
	always_comb begin
		cidx = idx_s6 + IW'(QN);
		sq = idx_s6[IW-1:IW-2];
		cq = cidx[IW-1:IW-2];
		sk = sq[0] ? KW'(QN) - KW'(idx_s6[IW-3:0]) : KW'(idx_s6[IW-3:0]);
		ck = cq[0] ? KW'(QN) - KW'(cidx[IW-3:0]) : KW'(cidx[IW-3:0]);
		sval = qtab[sk];
		cval = qtab[ck];
	end

	// stage 1: magnitude of heading, target folded to a signed half turn
	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s1 <= cmd_in;
			gneg_s1 <= gyro_in[23];
			gabs_s1 <= gyro_in[23] ? 24'(-gyro_in) : 24'(gyro_in);
			tadj_s1 <= (target_in > 13'(HALF_TURN)) ?
				$signed({1'b0, target_in}) - 14'sd5760 : $signed({1'b0, target_in});
		end
	end

	// stage 2: turns count by reciprocal
	always_ff @(posedge clk) begin
		if (en[1]) begin
			cmd_s2 <= cmd_s1;
			gneg_s2 <= gneg_s1;
			gabs_s2 <= gabs_s1;
			tadj_s2 <= tadj_s1;
			gq_s2 <= 11'(gprod >> REC_SHIFT);
		end
	end

	// stage 3: remainder of magnitude
	always_ff @(posedge clk) begin
		if (en[2]) begin
			cmd_s3 <= cmd_s2;
			gneg_s3 <= gneg_s2;
			tadj_s3 <= tadj_s2;
			r_s3 <= 13'(gabs_s2 - 24'(gq_s2) * 24'(FULL_TURN));
		end
	end

	// stage 4: truncating remainder and wrapped heading
	always_ff @(posedge clk) begin
		if (en[3]) begin
			cmd_s4 <= cmd_s3;
			tadj_s4 <= tadj_s3;
			g_s4 <= gneg_s3 ? -$signed({1'b0, r_s3}) : $signed({1'b0, r_s3});
			m_s4 <= (gneg_s3 && r_s3 != 13'd0) ? 13'(FULL_TURN) - r_s3 : r_s3;
		end
	end

	// stage 5: phase index estimate, hold error
	always_ff @(posedge clk) begin
		if (en[4]) begin
			cmd_s5 <= cmd_s4;
			iq_s5 <= (IW + 1)'(iprod >> REC_SHIFT);
			diff_s5 <= 15'(g_s4) - 15'(tadj_s4);
		end
	end

	// stage 6: index wrap, hold gain product
	always_ff @(posedge clk) begin
		if (en[5]) begin
			cmd_s6 <= cmd_s5;
			idx_s6 <= (iq_s5 >= (IW + 1)'(ENTRIES)) ?
				IW'(iq_s5 - (IW + 1)'(ENTRIES)) : IW'(iq_s5);
			hprod_s6 <= $signed({1'b0, hold_gain}) * diff_s5;
		end
	end

	// stage 7: table lookups, hold turn
	always_ff @(posedge clk) begin
		if (en[6]) begin
			cmd_s7 <= cmd_s6;
			sn_s7 <= sq[1] ? -$signed({1'b0, sval}) : $signed({1'b0, sval});
			cs_s7 <= cq[1] ? -$signed({1'b0, cval}) : $signed({1'b0, cval});
			turn_s7 <= 20'(hprod_s6 >>> 12);
		end
	end

	assign cmd_out  = cmd_s7;
	assign sn_out   = sn_s7;
	assign cs_out   = cs_s7;
	assign turn_out = turn_s7;

endmodule
`default_nettype wire

[rtl/mwm_div_step.sv]
// One restoring division step for the four normalisation lanes.
`default_nettype none
module mwm_div_step import mwm_pkg::*; #(
	parameter int J = 0
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [3:0][NUMW-1:0]   rem_in,
	input  wire logic [3:0][QW-1:0]     quo_in,
	input  wire logic [WW-1:0]          den_in,
	input  wire div_side_t              side_in,
	output logic [3:0][NUMW-1:0]        rem_out,
	output logic [3:0][QW-1:0]          quo_out,
	output logic [WW-1:0]               den_out,
	output div_side_t                   side_out
);

	logic [NUMW-1:0]          dsh;
	logic [3:0][NUMW-1:0]     rem_n;
	logic [3:0][QW-1:0]       quo_n;

	// trial subtract of the shifted divisor
	always_comb begin
		dsh = NUMW'(den_in) << J;
		for (int i = 0; i < 4; i++) begin
			if (rem_in[i] >= dsh) begin
				rem_n[i] = rem_in[i] - dsh;
				quo_n[i] = quo_in[i] | (QW'(1) << J);
			end else begin
				rem_n[i] = rem_in[i];
				quo_n[i] = quo_in[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_n;
			quo_out <= quo_n;
			den_out <= den_in;
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire

[rtl/mecanum_wheel_mixer.sv]
// Mecanum wheel mixer top level: mixing, normalisation, slow mode, output.
//
// One drive command enters on the s_ stream (operation in s_tuser, the
// command fields in s_tdata) and one result of four wheel values leaves on
// the m_ stream. Settings are written over the cfg_ channel; the user must
// write them only while no request is in flight, which the block itself
// does not enforce. cfg_ready is always high.
// The 28-stage pipeline takes a new request every cycle when the receiver
// keeps up; its depth is set by the 13 restoring steps of the normalising
// divider and the two reciprocal divisions of the heading by a full turn.
// Each stage holds only while the stage after it is full and stalled, so a
// stall on m_tready fills empty slots first and then pushes back to
// s_tready; nothing is dropped or repeated.
// Reset empties the pipeline and loads the default settings: slow mode off,
// slow scale one half, no wheel inverted, normalising on, hold gain 16.
`default_nettype none
module mecanum_wheel_mixer import mwm_pkg::*; #(
	parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	// strafe_x, forward_y, turn_rate, right_side, left_side, side_strafe,
	// target_angle, gyro_angle, zero pad
	input  wire logic [127:0]   s_tdata,
	// operation
	input  wire logic [1:0]     s_tuser,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	// front_left_drive, back_left_drive, front_right_drive, back_right_drive
	output logic [55:0]         m_tdata,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [15:0]    cfg_data
);

	localparam int ST_DIV0 = 13;
	localparam int ST_WN   = ST_DIV0 + QW;
	localparam int ST_PROD = ST_WN + 1;
	localparam int NST     = ST_PROD + 1;

	// settings
	logic        slow_on_q;
	logic [12:0] slow_scale_q;
	logic [3:0]  invert_q;
	logic        norm_on_q;
	logic [15:0] hold_gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_on_q <= 1'b0;
			slow_scale_q <= 13'd2048;
			invert_q <= 4'd0;
			norm_on_q <= 1'b1;
			hold_gain_q <= 16'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SLOW_ON: slow_on_q <= cfg_data[0];
				CFG_SLOW_SCALE: slow_scale_q <= cfg_data[12:0];
				CFG_INVERT: invert_q <= cfg_data[3:0];
				CFG_NORM_ON: norm_on_q <= cfg_data[0];
				CFG_HOLD_GAIN: hold_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	logic [NST:1]   vld_q;
	logic [NST:1]   vin;
	logic [NST+1:1] en;

	always_comb begin
		en[NST+1] = m_tready;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vin = {vld_q[NST-1:1], s_tvalid};
	assign s_tready = en[1];
	assign m_tvalid = vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	// unpack the request
	cmd_t cmd_in;
	assign cmd_in.op   = s_tuser;
	assign cmd_in.x    = s_tdata[13:0];
	assign cmd_in.y    = s_tdata[27:14];
	assign cmd_in.turn = s_tdata[41:28];
	assign cmd_in.rs   = s_tdata[55:42];
	assign cmd_in.ls   = s_tdata[69:56];
	assign cmd_in.st   = s_tdata[83:70];

	// stages 1 to 7
	cmd_t                 cmd_h;
	logic signed [DW-1:0] sn_h, cs_h;
	logic signed [19:0]   turn_h;

	mwm_heading #(
		.ENTRIES(SINE_TABLE_ENTRIES)
	) u_heading (
		.clk(clk),
		.en(en[7:1]),
		.cmd_in(cmd_in),
		.target_in(s_tdata[96:84]),
		.gyro_in(s_tdata[120:97]),
		.hold_gain(hold_gain_q),
		.cmd_out(cmd_h),
		.sn_out(sn_h),
		.cs_out(cs_h),
		.turn_out(turn_h)
	);

	function automatic logic signed [17:0] rnd_rot(input logic signed [28:0] s);
		logic [28:0] mag;
		logic [16:0] r;
		mag = s[28] ? 29'(-s) : 29'(s);
		r = 17'((mag + 29'd2048) >> 12);
		return s[28] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	function automatic logic signed [24:0] rnd_slow(input logic signed [35:0] s);
		logic [35:0] mag;
		logic [23:0] r;
		mag = s[35] ? 36'(-s) : 36'(s);
		r = 24'((mag + 36'd2048) >> 12);
		return s[35] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	// stage 8: rotation products
	cmd_t               cmd_s8;
	logic signed [27:0] pxc_s8, pys_s8, pxs_s8, pyc_s8;
	logic signed [19:0] turn_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			cmd_s8 <= cmd_h;
			pxc_s8 <= cmd_h.x * cs_h;
			pys_s8 <= cmd_h.y * sn_h;
			pxs_s8 <= cmd_h.x * sn_h;
			pyc_s8 <= cmd_h.y * cs_h;
			turn_s8 <= (cmd_h.op == OP_HOLD) ? turn_h : 20'(cmd_h.turn);
		end
	end

	// stage 9: rotated x and y
	cmd_t               cmd_s9;
	logic signed [17:0] x_s9, y_s9;
	logic signed [19:0] turn_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			cmd_s9 <= cmd_s8;
			turn_s9 <= turn_s8;
			if (cmd_s8.op == OP_FIELD) begin
				x_s9 <= rnd_rot(29'(pxc_s8) - 29'(pys_s8));
				y_s9 <= rnd_rot(29'(pxs_s8) + 29'(pyc_s8));
			end else begin
				x_s9 <= 18'(cmd_s8.x);
				y_s9 <= 18'(cmd_s8.y);
			end
		end
	end

	// stage 10: wheel mix
	logic signed [WW-1:0] w_s10 [4];

	always_ff @(posedge clk) begin
		if (en[10]) begin
			if (cmd_s9.op == OP_RL_STRAFE) begin
				w_s10[0] <= WW'(cmd_s9.ls) + WW'(cmd_s9.st);
				w_s10[1] <= WW'(cmd_s9.ls) - WW'(cmd_s9.st);
				w_s10[2] <= WW'(cmd_s9.rs) - WW'(cmd_s9.st);
				w_s10[3] <= WW'(cmd_s9.rs) + WW'(cmd_s9.st);
			end else begin
				w_s10[0] <= WW'(y_s9) + WW'(x_s9) + WW'(turn_s9);
				w_s10[1] <= WW'(y_s9) - WW'(x_s9) + WW'(turn_s9);
				w_s10[2] <= WW'(y_s9) - WW'(x_s9) - WW'(turn_s9);
				w_s10[3] <= WW'(y_s9) + WW'(x_s9) - WW'(turn_s9);
			end
		end
	end

	// stage 11: magnitudes and largest one
	logic [3:0][WW-1:0] a_c;
	logic [WW-1:0]      mx_c;
	logic [3:0][WW-1:0] a_s11;
	logic [3:0][WW-1:0] w_s11;
	logic [3:0]         neg_s11;
	logic [WW-1:0]      max_s11;
	logic               act_s11;

	always_comb begin
		mx_c = WW'(Q12_ONE);
		for (int i = 0; i < 4; i++) begin
			a_c[i] = w_s10[i][WW-1] ? WW'(-w_s10[i]) : WW'(w_s10[i]);
			if (a_c[i] > mx_c) begin
				mx_c = a_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			for (int i = 0; i < 4; i++) begin
				a_s11[i] <= a_c[i];
				w_s11[i] <= w_s10[i];
				neg_s11[i] <= w_s10[i][WW-1];
			end
			max_s11 <= mx_c;
			act_s11 <= norm_on_q && (mx_c > WW'(Q12_ONE));
		end
	end

	// stage 12: dividend with half divisor for rounding
	logic [3:0][NUMW-1:0] num_s12;
	logic [WW-1:0]        den_s12;
	div_side_t            side_s12;

	always_ff @(posedge clk) begin
		if (en[12]) begin
			for (int i = 0; i < 4; i++) begin
				num_s12[i] <= (NUMW'(a_s11[i]) << 12) + NUMW'(max_s11 >> 1);
			end
			den_s12 <= max_s11;
			side_s12.act <= act_s11;
			side_s12.neg <= neg_s11;
			side_s12.w <= w_s11;
		end
	end

	// stages 13 to 25: one quotient bit per stage
	logic [3:0][NUMW-1:0] rem_c  [QW+1];
	logic [3:0][QW-1:0]   quo_c  [QW+1];
	logic [WW-1:0]        den_c  [QW+1];
	div_side_t            side_c [QW+1];

	assign rem_c[0]  = num_s12;
	assign quo_c[0]  = '0;
	assign den_c[0]  = den_s12;
	assign side_c[0] = side_s12;

	for (genvar d = 0; d < QW; d++) begin : g_div
		mwm_div_step #(
			.J(QW - 1 - d)
		) u_step (
			.clk(clk),
			.en(en[ST_DIV0 + d]),
			.rem_in(rem_c[d]),
			.quo_in(quo_c[d]),
			.den_in(den_c[d]),
			.side_in(side_c[d]),
			.rem_out(rem_c[d+1]),
			.quo_out(quo_c[d+1]),
			.den_out(den_c[d+1]),
			.side_out(side_c[d+1])
		);
	end

	// stage 26: normalised or raw wheel value
	logic signed [WW-1:0] wn_s26 [4];

	always_ff @(posedge clk) begin
		if (en[ST_WN]) begin
			for (int i = 0; i < 4; i++) begin
				if (side_c[QW].act) begin
					wn_s26[i] <= side_c[QW].neg[i] ?
						-WW'($signed({1'b0, quo_c[QW][i]})) :
						WW'($signed({1'b0, quo_c[QW][i]}));
				end else begin
					wn_s26[i] <= $signed(side_c[QW].w[i]);
				end
			end
		end
	end

	// stage 27: slow mode product, unity when slow mode is off
	logic signed [13:0] fac;
	logic signed [35:0] sp_s27 [4];

	assign fac = slow_on_q ? $signed({1'b0, slow_scale_q}) : 14'sd4096;

	always_ff @(posedge clk) begin
		if (en[ST_PROD]) begin
			for (int i = 0; i < 4; i++) begin
				sp_s27[i] <= 36'(wn_s26[i]) * 36'(fac);
			end
		end
	end

	// stage 28: round, invert, saturate
	logic signed [25:0]   v_c [4];
	logic signed [DW-1:0] out_s28 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			v_c[i] = 26'(rnd_slow(sp_s27[i]));
			if (invert_q[i]) begin
				v_c[i] = -v_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			for (int i = 0; i < 4; i++) begin
				if (v_c[i] > 26'sd4096) begin
					out_s28[i] <= 14'sd4096;
				end else if (v_c[i] < -26'sd4096) begin
					out_s28[i] <= -14'sd4096;
				end else begin
					out_s28[i] <= 14'(v_c[i]);
				end
			end
		end
	end

	assign m_tdata = {out_s28[3], out_s28[2], out_s28[1], out_s28[0]};

endmodule
`default_nettype wire

[verif/tb_mecanum_wheel_mixer.sv]
// Self-checking testbench for the mecanum wheel mixer stream block.
`timescale 1ns / 100ps
`default_nettype none
module tb_mecanum_wheel_mixer;
	import mwm_pkg::*;

	localparam int  TABLE_N     = 1024;
	localparam int  DRAIN_WAIT  = 40;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [13:0] fl;
		logic signed [13:0] bl;
		logic signed [13:0] fr;
		logic signed [13:0] br;
	} wheels_t;

	typedef struct {
		logic [1:0]          op;
		logic signed [13:0]  x;
		logic signed [13:0]  y;
		logic signed [13:0]  turn;
		logic signed [13:0]  rs;
		logic signed [13:0]  ls;
		logic signed [13:0]  st;
		logic [12:0]         target;
		logic signed [23:0]  gyro;
	} drive_cmd_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [15:0]  cfg_data;

	// local copy of the settings
	logic         slow_on_r;
	logic [12:0]  slow_scale_r;
	logic [3:0]   invert_r;
	logic         norm_on_r;
	logic [15:0]  hold_gain_r;

	wheels_t      wheels_due[$];
	int           tx_idle_pct;
	int           rx_idle_pct;
	int           mismatches;
	longint       cycles;

	mecanum_wheel_mixer u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// first quadrant sine, Q30 radians in, Q12 out
	function automatic longint quadrant_sine(longint unsigned ang);
		longint unsigned a2, s3, s5, s7, s9;
		longint sum;
		a2 = (ang * ang) >> 30;
		s3 = ((ang * a2) >> 30) / 6;
		s5 = ((s3 * a2) >> 30) / 20;
		s7 = ((s5 * a2) >> 30) / 42;
		s9 = ((s7 * a2) >> 30) / 72;
		sum = longint'(ang) - longint'(s3) + longint'(s5) - longint'(s7) + longint'(s9);
		if (sum < 0) begin
			sum = 0;
		end
		return longint'(($unsigned(sum) + 131072) >> 18);
	endfunction

	// table sine of a heading in 0..5759 sixteenth degrees
	function automatic longint table_sine(longint hdg);
		longint unsigned idx, p, quad, rem, ang;
		longint v;
		idx = ($unsigned(hdg) * TABLE_N + HALF_TURN) / FULL_TURN;
		if (idx >= TABLE_N) begin
			idx -= TABLE_N;
		end
		p = idx * 4;
		quad = p / TABLE_N;
		rem = p % TABLE_N;
		if (quad[0]) begin
			rem = TABLE_N - rem;
		end
		ang = (HALF_PI_Q30 * rem) / TABLE_N;
		v = quadrant_sine(ang);
		return quad[1] ? -v : v;
	endfunction

	function automatic longint wrap_turn(longint g);
		longint m;
		m = g % FULL_TURN;
		if (m < 0) begin
			m += FULL_TURN;
		end
		return m;
	endfunction

	// Q12 rounding, halves away from zero
	function automatic longint round_q12(longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + 2048) >>> 12;
		return (v < 0) ? -mag : mag;
	endfunction

	// wheel values for one command under the current settings
	function automatic wheels_t mix_wheels(drive_cmd_t c);
		longint w[4];
		longint x, y, t, hdg, sn, cs, xr, g, tg, peak, a, q, v;
		logic signed [13:0] o[4];
		wheels_t r;
		x = c.x;
		y = c.y;
		t = c.turn;
		if (c.op == OP_RL_STRAFE) begin
			w[0] = longint'(c.ls) + c.st;
			w[1] = longint'(c.ls) - c.st;
			w[2] = longint'(c.rs) - c.st;
			w[3] = longint'(c.rs) + c.st;
		end else begin
			if (c.op == OP_FIELD) begin
				hdg = wrap_turn(c.gyro);
				sn = table_sine(hdg);
				cs = table_sine(wrap_turn(hdg + 1440));
				xr = round_q12(x * cs - y * sn);
				y = round_q12(x * sn + y * cs);
				x = xr;
			end else if (c.op == OP_HOLD) begin
				g = longint'(c.gyro) % FULL_TURN;
				tg = (c.target > HALF_TURN) ? longint'(c.target) - FULL_TURN : longint'(c.target);
				t = (longint'(hold_gain_r) * (g - tg)) >>> 12;
			end
			w[0] = y + x + t;
			w[1] = y - x + t;
			w[2] = y - x - t;
			w[3] = y + x - t;
		end
		if (norm_on_r) begin
			peak = Q12_ONE;
			foreach (w[i]) begin
				a = (w[i] < 0) ? -w[i] : w[i];
				if (a > peak) begin
					peak = a;
				end
			end
			if (peak > Q12_ONE) begin
				foreach (w[i]) begin
					a = (w[i] < 0) ? -w[i] : w[i];
					q = (a * Q12_ONE + peak / 2) / peak;
					w[i] = (w[i] < 0) ? -q : q;
				end
			end
		end
		foreach (w[i]) begin
			v = w[i];
			if (slow_on_r) begin
				v = round_q12(v * longint'(slow_scale_r));
			end
			if (invert_r[i]) begin
				v = -v;
			end
			if (v > Q12_ONE) begin
				v = Q12_ONE;
			end
			if (v < -Q12_ONE) begin
				v = -Q12_ONE;
			end
			o[i] = v[13:0];
		end
		r.fl = o[0];
		r.bl = o[1];
		r.fr = o[2];
		r.br = o[3];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [13:0] got, logic [13:0] want);
		$display("[%0t] mismatch %s: got %0d want %0d", $realtime, what,
			$signed(got), $signed(want));
		mismatches++;
	endtask

	// receiver: random back-pressure and result checking
	always @(posedge clk or negedge arst_n) begin
		wheels_t want;
		wheels_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
			if (m_tvalid && m_tready) begin
				// front left sits in the lowest bits
				got = {m_tdata[13:0], m_tdata[27:14], m_tdata[41:28], m_tdata[55:42]};
				if (wheels_due.size() == 0) begin
					report_mismatch("unexpected result", got.fl, 14'd0);
				end else begin
					want = wheels_due.pop_front();
					if (got.fl !== want.fl) report_mismatch("front_left", got.fl, want.fl);
					if (got.bl !== want.bl) report_mismatch("back_left", got.bl, want.bl);
					if (got.fr !== want.fr) report_mismatch("front_right", got.fr, want.fr);
					if (got.br !== want.br) report_mismatch("back_right", got.br, want.br);
				end
			end
		end
	end

	// send one command, wait for acceptance, then idle cycle by cycle
	task automatic send_cmd(drive_cmd_t c);
		s_tvalid <= 1'b1;
		s_tuser  <= c.op;
		s_tdata  <= {7'd0, c.gyro, c.target, c.st, c.ls, c.rs, c.turn, c.y, c.x};
		do @(posedge clk); while (!s_tready);
		wheels_due.push_back(mix_wheels(c));
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold the sender until every result is back, then let the pipe settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (wheels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_setting(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SLOW_ON:    slow_on_r    = val[0];
			CFG_SLOW_SCALE: slow_scale_r = val[12:0];
			CFG_INVERT:     invert_r     = val[3:0];
			CFG_NORM_ON:    norm_on_r    = val[0];
			CFG_HOLD_GAIN:  hold_gain_r  = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic drive_cmd_t make_cmd(logic [1:0] op, int x, int y, int t,
			int tg, int gy);
		drive_cmd_t c;
		c.op = op;
		c.x = 14'(x); c.y = 14'(y); c.turn = 14'(t);
		c.rs = 14'(x); c.ls = 14'(y); c.st = 14'(t);
		c.target = 13'(tg);
		c.gyro = 24'(gy);
		return c;
	endfunction

	function automatic int rand_q12();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return $signed(14'($urandom));
		if (pick == 1) return ($urandom_range(1)) ? 4096 : -4096;
		return $urandom_range(8192) - 4096;
	endfunction

	function automatic drive_cmd_t rand_cmd();
		drive_cmd_t c;
		c.op = 2'($urandom_range(3));
		c.x = 14'(rand_q12()); c.y = 14'(rand_q12()); c.turn = 14'(rand_q12());
		c.rs = 14'(rand_q12()); c.ls = 14'(rand_q12()); c.st = 14'(rand_q12());
		c.target = ($urandom_range(4) == 0) ? 13'($urandom) : 13'($urandom_range(5760));
		if ($urandom_range(1))
			c.gyro = 24'($urandom);
		else
			c.gyro = 24'($urandom_range(23040) - 11520);
		return c;
	endfunction

	// extremes, every mode and the hold-mode corner cases at reset settings
	task automatic test_directed();
		send_cmd(make_cmd(OP_XY_TURN, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_XY_TURN, 4096, 4096, 4096, 0, 0));
		send_cmd(make_cmd(OP_XY_TURN, -4096, -4096, -4096, 0, 0));
		send_cmd(make_cmd(OP_XY_TURN, -8192, 8191, -1, 8191, -8388608));
		send_cmd(make_cmd(OP_RL_STRAFE, 4096, -4096, 4096, 0, 0));
		send_cmd(make_cmd(OP_RL_STRAFE, -8192, 8191, 8191, 0, 0));
		send_cmd(make_cmd(OP_RL_STRAFE, 100, 200, -300, 5000, 12345));
		send_cmd(make_cmd(OP_FIELD, 4096, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_FIELD, 4096, 4096, 1000, 0, 1440));
		send_cmd(make_cmd(OP_FIELD, -4096, 2048, 0, 0, -720));
		send_cmd(make_cmd(OP_FIELD, 3000, -3000, 0, 0, 8388607));
		send_cmd(make_cmd(OP_FIELD, 4096, 4096, 4096, 0, -8388608));
		send_cmd(make_cmd(OP_FIELD, 2000, 1000, 0, 0, 5759));
		// hold: negative heading keeps its sign after reduction
		send_cmd(make_cmd(OP_HOLD, 0, 0, 0, 0, -100));
		send_cmd(make_cmd(OP_HOLD, 0, 0, 0, 100, -5800));
		// hold: targets above half a turn, and beyond a full turn
		send_cmd(make_cmd(OP_HOLD, 500, 500, 0, 2881, 0));
		send_cmd(make_cmd(OP_HOLD, 0, 0, 0, 5760, 10));
		send_cmd(make_cmd(OP_HOLD, 0, 1000, 0, 8191, 8388607));
		send_cmd(make_cmd(OP_HOLD, 0, 0, 0, 2880, -8388608));
		drain_results();
	endtask

	// each register at its extremes, a handful of commands per setting
	task automatic test_register_extremes();
		logic [15:0] vals[3];
		vals = '{16'd0, 16'hFFFF, 16'd4096};
		for (int r = 0; r < 6; r++) begin
			foreach (vals[v]) begin
				write_setting(r[2:0], vals[v]);
				repeat (6) send_cmd(rand_cmd());
				drain_results();
			end
		end
		write_setting(CFG_SLOW_ON, 16'd1);
		write_setting(CFG_SLOW_SCALE, 16'd4096);
		write_setting(CFG_INVERT, 16'd15);
		write_setting(CFG_NORM_ON, 16'd0);
		write_setting(CFG_HOLD_GAIN, 16'd65535);
		repeat (10) send_cmd(rand_cmd());
		drain_results();
	endtask

	// random commands under random settings and a given idling pattern
	task automatic test_random(int n, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int phase = 0; phase < 4; phase++) begin
			write_setting(CFG_SLOW_ON, 16'($urandom_range(1)));
			write_setting(CFG_SLOW_SCALE, ($urandom_range(3) == 0) ? 16'($urandom) :
				16'($urandom_range(4096)));
			write_setting(CFG_INVERT, 16'($urandom_range(15)));
			write_setting(CFG_NORM_ON, 16'($urandom_range(1)));
			write_setting(CFG_HOLD_GAIN, ($urandom_range(1)) ? 16'($urandom) :
				16'($urandom_range(64)));
			repeat (n / 4) send_cmd(rand_cmd());
			drain_results();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_XY_TURN;
		cfg_valid = 1'b0;
		cfg_index = CFG_SLOW_ON;
		cfg_data = '0;
		cycles = 0;
		mismatches = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		slow_on_r = 1'b0;
		slow_scale_r = 13'd2048;
		invert_r = 4'd0;
		norm_on_r = 1'b1;
		hold_gain_r = 16'd16;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_random(280, 30, 88);
		test_random(280, 88, 30);
		test_random(280, 0, 0);

		drain_results();
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
rtl/mwm_pkg.sv
rtl/mwm_heading.sv
rtl/mwm_div_step.sv
rtl/mecanum_wheel_mixer.sv
verif/tb_mecanum_wheel_mixer.sv
